FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bridge path builder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BBP_ASSERT_IMP(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("bbp assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BBP_ASSERT_NXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("bbp assertion failed");

`endif

FILE: rtl/bbp_pkg.sv
// ----------------------------------------------------------------------------
// bbp_pkg
// Widths, constants and the bridge scale table of the path builder.
// ----------------------------------------------------------------------------
package bbp_pkg;

	localparam int Z_W     = 18;  // normal sample, 14 fractional bits
	localparam int SS_W    = 17;  // sqrt(h), 16 fractional bits
	localparam int PT_W    = 24;  // path point / increment, 14 fractional bits
	localparam int STEP_W  = 6;   // step index on the result channel
	localparam int G_W     = 20;  // bridge scale, 16 fractional bits
	localparam int G_IDX_W = 8;   // scale table index
	localparam int G_DEPTH = 129; // scale table entries
	localparam int SUM_W   = PT_W + 1;
	localparam int P1_W    = Z_W + SS_W + 1;
	localparam int P2_W    = P1_W + G_W + 1;
	localparam int ACC_W   = P2_W + 1;
	localparam int RND_SH  = 32;  // 46 fractional bits down to 14
	localparam int SUM_SH  = 31;  // point sum alignment to 46 fractional bits

	localparam logic [SS_W-1:0] SS_RESET = SS_W'(8192);

	typedef logic [G_DEPTH-1:0][G_W-1:0] g_table_t;

	// Integer square root of a 64-bit value, rounded to nearest
	function automatic logic [63:0] isqrt_round(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] v;
		r = '0;
		v = x;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (b != '0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		if (x - r * r > r) begin
			r = r + 64'd1;
		end
		return r;
	endfunction

	// Entry m holds round(sqrt(m/2) * 2^16)
	function automatic g_table_t build_g_table();
		g_table_t t;
		for (int m = 0; m < G_DEPTH; m++) begin
			t[m] = G_W'(isqrt_round(64'(m) << 31));
		end
		return t;
	endfunction

	localparam g_table_t G_TABLE = build_g_table();

endpackage

FILE: rtl/bbp_if.sv
// ----------------------------------------------------------------------------
// bbp_if
// Valid/ready channels of the path builder: sample requests in,
// increment requests out.
// ----------------------------------------------------------------------------
interface bbp_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [bbp_pkg::Z_W-1:0]    normal_sample;

	modport source (output valid, output normal_sample, input ready);
	modport sink   (input valid, input normal_sample, output ready);
endinterface

interface bbp_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [bbp_pkg::PT_W-1:0]   increment;
	logic [bbp_pkg::STEP_W-1:0]        step_index;
	logic                              last_of_path;

	modport source (output valid, output increment, output step_index,
		output last_of_path, input ready);
	modport sink   (input valid, input increment, input step_index,
		input last_of_path, output ready);
endinterface

FILE: rtl/brownian_bridge_path_builder_unit.sv
// Flow: a sample request is accepted in idle (low point read), then passes the
// high point read, multiply, accumulate and write-back states; the next sample
// is accepted once the block is idle again. After the last sample of a path the
// increments stream out, each by a point read and then an output load that
// waits while the held result has not been taken.
// Reset (arst_n low): sample count zero, all points read zero, step_sqrt 8192.
// ----------------------------------------------------------------------------
// brownian_bridge_path_builder_unit
// Brownian bridge path construction over a uniform grid: samples arrive in
// bridge order, points live in a synchronous memory, increments stream out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brownian_bridge_path_builder_unit #(
	parameter int PATH_STEPS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bbp_pkg::SS_W-1:0]      cfg_wdata,
	bbp_in_if.sink                        sample,
	bbp_out_if.source                     result
);

	localparam int CW     = $clog2(PATH_STEPS);
	localparam int PW     = $clog2(PATH_STEPS + 1);
	localparam int LVW    = $clog2(CW + 1);
	localparam int LEVELS = $clog2(PATH_STEPS + 1) - 1;
	localparam int PT_W   = bbp_pkg::PT_W;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_RD_HI  = 7'b0000010,
		ST_MUL    = 7'b0000100,
		ST_ACC    = 7'b0001000,
		ST_WR     = 7'b0010000,
		ST_EM_RD  = 7'b0100000,
		ST_EM_OUT = 7'b1000000
	} state_t;

	state_t                         state_q;
	state_t                         state_d;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  k_q;
	logic [bbp_pkg::SS_W-1:0]       ss_q;
	logic signed [bbp_pkg::Z_W-1:0] z_q;
	logic [bbp_pkg::G_W-1:0]        g_q;
	logic [PW-1:0]                  hi_q;
	logic [PW-1:0]                  mid_q;
	logic                           wr_ok_q;
	logic                           last_q;
	logic signed [PT_W-1:0]         lo_pt_q;
	logic signed [PT_W-1:0]         prev_q;
	logic                           out_valid_q;
	logic signed [PT_W-1:0]         out_incr_q;
	logic [bbp_pkg::STEP_W-1:0]     out_step_q;
	logic                           out_last_q;

	logic                           accept;
	logic                           start;
	logic                           last_sample;
	logic [LVW-1:0]                 level;
	logic [CW-1:0]                  j;
	logic [PW-1:0]                  stride;
	logic [PW-1:0]                  half;
	logic [CW+PW-1:0]               lo_w;
	logic [PW-1:0]                  lo_c;
	logic [PW-1:0]                  hi_c;
	logic [PW-1:0]                  mid_c;
	logic                           wr_ok_c;
	logic [bbp_pkg::G_IDX_W-1:0]    g_idx;
	logic [PW-1:0]                  rd_pt;
	logic signed [PT_W-1:0]         rd_data;
	logic signed [PT_W-1:0]         new_pt;
	logic signed [bbp_pkg::SUM_W-1:0] sum;
	logic signed [PT_W:0]           diff;
	logic signed [PT_W-1:0]         diff_sat;
	logic                           mem_wr;
	logic                           out_load;
	logic                           last_k;

	// Handshake
	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign start        = (count_q == '0);
	assign last_sample  = (count_q == CW'(PATH_STEPS - 1));

	// Level of the sample count: position of its top set bit
	always_comb begin
		level = '0;
		for (int b = 1; b < CW; b++) begin
			if (count_q[b]) begin
				level = LVW'(b);
			end
		end
	end

	// Bisection interval of this sample
	assign j      = count_q - (CW'(1) << level);
	assign stride = PW'(PATH_STEPS) >> level;
	assign half   = stride >> 1;
	assign lo_w   = (CW+PW)'(j) * (CW+PW)'(stride);

	always_comb begin
		if (start) begin
			lo_c    = '0;
			hi_c    = '0;
			mid_c   = PW'(PATH_STEPS);
			g_idx   = bbp_pkg::G_IDX_W'(2 * PATH_STEPS);
			wr_ok_c = 1'b1;
		end else begin
			lo_c    = lo_w[PW-1:0];
			hi_c    = lo_w[PW-1:0] + stride;
			mid_c   = lo_w[PW-1:0] + half;
			g_idx   = bbp_pkg::G_IDX_W'(half);
			wr_ok_c = (level < LVW'(LEVELS)) && (half != '0)
				&& (hi_c <= PW'(PATH_STEPS));
		end
	end

	// Memory read address per state
	always_comb begin
		unique case (state_q)
			ST_IDLE:   rd_pt = lo_c;
			ST_RD_HI:  rd_pt = hi_q;
			ST_EM_RD,
			ST_EM_OUT: rd_pt = PW'(k_q) + PW'(1);
			default:   rd_pt = '0;
		endcase
	end

	assign mem_wr   = (state_q == ST_WR) && wr_ok_q;
	assign sum      = bbp_pkg::SUM_W'(lo_pt_q) + bbp_pkg::SUM_W'(rd_data);
	assign last_k   = (k_q == CW'(PATH_STEPS - 1));
	assign out_load = (state_q == ST_EM_OUT) && (!out_valid_q || result.ready);

	// Increment between neighboring points, saturated
	assign diff = (PT_W+1)'(rd_data) - (PT_W+1)'(prev_q);
	always_comb begin
		if (diff[PT_W] == diff[PT_W-1]) begin
			diff_sat = diff[PT_W-1:0];
		end else if (diff[PT_W]) begin
			diff_sat = {1'b1, {(PT_W-1){1'b0}}};
		end else begin
			diff_sat = {1'b0, {(PT_W-1){1'b1}}};
		end
	end

	bbp_point_mem #(
		.DEPTH (PATH_STEPS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (accept && start),
		.wr_en   (mem_wr),
		.wr_pt   (mid_q),
		.wr_data (new_pt),
		.rd_pt   (rd_pt),
		.rd_data (rd_data)
	);

	bbp_mid_unit u_mid (
		.clk       (clk),
		.z         (z_q),
		.step_sqrt (ss_q),
		.g         (g_q),
		.sum       (sum),
		.point     (new_pt)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) begin
				state_d = ST_RD_HI;
			end
			ST_RD_HI:  state_d = ST_MUL;
			ST_MUL:    state_d = ST_ACC;
			ST_ACC:    state_d = ST_WR;
			ST_WR:     state_d = last_q ? ST_EM_RD : ST_IDLE;
			ST_EM_RD:  state_d = ST_EM_OUT;
			ST_EM_OUT: if (out_load) begin
				state_d = last_k ? ST_IDLE : ST_EM_RD;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			ss_q        <= bbp_pkg::SS_RESET;
			wr_ok_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				ss_q <= cfg_wdata;
			end
			// advance the sample count, wrap at path end
			if (accept) begin
				count_q <= last_sample ? '0 : count_q + CW'(1);
				wr_ok_q <= wr_ok_c;
				last_q  <= last_sample;
			end
			// advance the emitted step
			if (out_load) begin
				k_q <= last_k ? '0 : k_q + CW'(1);
			end
			// hold the result until taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			z_q   <= sample.normal_sample;
			g_q   <= bbp_pkg::G_TABLE[g_idx];
			hi_q  <= hi_c;
			mid_q <= mid_c;
		end
		if (state_q == ST_RD_HI) begin
			lo_pt_q <= rd_data;
		end
		if (state_q == ST_WR) begin
			prev_q <= '0;
		end else if (out_load) begin
			prev_q <= rd_data;
		end
		if (out_load) begin
			out_incr_q <= diff_sat;
			out_step_q <= bbp_pkg::STEP_W'(k_q);
			out_last_q <= last_k;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.increment    = out_incr_q;
	assign result.step_index   = out_step_q;
	assign result.last_of_path = out_last_q;

	// Points change only in the write-back step
	`BBP_ASSERT_IMP(a_wr_in_wb, clk, arst_n, mem_wr, state_q == ST_WR)
	// Final increment of a path leaves the block idle with a fresh count
	`BBP_ASSERT_NXT(a_path_end, clk, arst_n, out_load && last_k, count_q == '0 && state_q == ST_IDLE)
	// Write-back goes on to the next sample or to emission
	`BBP_ASSERT_NXT(a_wb_next, clk, arst_n, state_q == ST_WR, state_q == ST_IDLE || state_q == ST_EM_RD)

endmodule

FILE: rtl/bbp_point_mem.sv
// ----------------------------------------------------------------------------
// bbp_point_mem
// Path point store: points 1..DEPTH in a synchronous memory with a registered
// read port. Per-entry valid bits make unwritten points read as zero;
// point zero always reads as zero.
// ----------------------------------------------------------------------------
module bbp_point_mem #(
	parameter int DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clr,
	input  logic                              wr_en,
	input  logic [$clog2(DEPTH+1)-1:0]        wr_pt,
	input  logic signed [bbp_pkg::PT_W-1:0]   wr_data,
	input  logic [$clog2(DEPTH+1)-1:0]        rd_pt,
	output logic signed [bbp_pkg::PT_W-1:0]   rd_data
);

	localparam int PW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic signed [bbp_pkg::PT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]                valid_q;
	logic [PW-1:0]                   wr_pt_m1;
	logic [PW-1:0]                   rd_pt_m1;
	logic [AW-1:0]                   wr_addr;
	logic [AW-1:0]                   rd_addr;
	logic signed [bbp_pkg::PT_W-1:0] rd_q;
	logic                            rd_ok_q;

	// Map point index to memory address
	assign wr_pt_m1 = wr_pt - PW'(1);
	assign rd_pt_m1 = rd_pt - PW'(1);
	assign wr_addr  = wr_pt_m1[AW-1:0];
	assign rd_addr  = rd_pt_m1[AW-1:0];

	// Track written entries; drop them all at path start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_q    <= mem[rd_addr];
		rd_ok_q <= (rd_pt != '0) && valid_q[rd_addr];
	end

	assign rd_data = rd_ok_q ? rd_q : '0;

endmodule

FILE: rtl/bbp_mid_unit.sv
// ----------------------------------------------------------------------------
// bbp_mid_unit
// Three-stage point datapath: z*step_sqrt, times the bridge scale, plus the
// aligned sum of the interval ends; then round half away from zero to 14
// fractional bits and saturate to 24 bits.
// ----------------------------------------------------------------------------
module bbp_mid_unit (
	input  logic                                clk,
	input  logic signed [bbp_pkg::Z_W-1:0]      z,
	input  logic [bbp_pkg::SS_W-1:0]            step_sqrt,
	input  logic [bbp_pkg::G_W-1:0]             g,
	input  logic signed [bbp_pkg::SUM_W-1:0]    sum,
	output logic signed [bbp_pkg::PT_W-1:0]     point
);

	localparam int ACC_W = bbp_pkg::ACC_W;
	localparam int SH_W  = ACC_W - bbp_pkg::RND_SH;

	logic signed [bbp_pkg::SS_W:0]        ss_s;
	logic signed [bbp_pkg::G_W:0]         g_s;
	logic signed [bbp_pkg::P1_W-1:0]      p1_s1;
	logic signed [bbp_pkg::P2_W-1:0]      p2_s2;
	logic signed [bbp_pkg::SUM_W-1:0]     sum_s2;
	logic signed [ACC_W-1:0]              acc_s3;
	logic [ACC_W-1:0]                     bias;
	logic signed [ACC_W-1:0]              rnd;
	logic signed [SH_W-1:0]               sh;

	assign ss_s = $signed({1'b0, step_sqrt});
	assign g_s  = $signed({1'b0, g});

	// Stage 1: sample times sqrt(h)
	always_ff @(posedge clk) begin
		p1_s1 <= bbp_pkg::P1_W'(z) * bbp_pkg::P1_W'(ss_s);
	end

	// Stage 2: times bridge scale, capture interval end sum
	always_ff @(posedge clk) begin
		p2_s2  <= bbp_pkg::P2_W'(p1_s1) * bbp_pkg::P2_W'(g_s);
		sum_s2 <= sum;
	end

	// Stage 3: add the mean term at 46 fractional bits
	always_ff @(posedge clk) begin
		acc_s3 <= ACC_W'(p2_s2) + (ACC_W'(sum_s2) <<< bbp_pkg::SUM_SH);
	end

	// Round half away from zero: bias is one less for negative values
	assign bias = (ACC_W'(1'b1) << (bbp_pkg::RND_SH - 1)) - ACC_W'(acc_s3[ACC_W-1]);
	assign rnd  = acc_s3 + $signed(bias);
	assign sh   = rnd[ACC_W-1:bbp_pkg::RND_SH];

	// Saturate to the point range
	always_comb begin
		if (sh[SH_W-1:bbp_pkg::PT_W-1] == '0 || sh[SH_W-1:bbp_pkg::PT_W-1] == '1) begin
			point = sh[bbp_pkg::PT_W-1:0];
		end else if (sh[SH_W-1]) begin
			point = {1'b1, {(bbp_pkg::PT_W-1){1'b0}}};
		end else begin
			point = {1'b0, {(bbp_pkg::PT_W-1){1'b1}}};
		end
	end

endmodule
